@@ hdl/stmg_pkg.sv @@
// Package for the two-axis stepper motion generator.
// Holds the controller states, the command and status records and the fixed codes.
// No dependencies.
`default_nettype none

package stmg_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_ZERO  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [1:0] CFG_MIN_RPM  = 2'd0;
  localparam logic [1:0] CFG_MAX_RPM  = 2'd1;
  localparam logic [1:0] CFG_ACC_FRAC = 2'd2;
  localparam logic [1:0] CFG_DEC_FRAC = 2'd3;

  localparam logic [31:0] PERIOD_NUM = 32'd30000000;
  localparam logic [15:0] PERIOD_MAX = 16'hFFFF;

  localparam int DIVIDEND_W = 32;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 88;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEL,
    ST_RWAIT,
    ST_PMUL,
    ST_PSEL,
    ST_PWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic sel;
    logic rdone;
    logic pmul;
    logic psel;
    logic pdone;
    logic oload;
  } cmd_t;

  typedef struct packed {
    logic step_go;
    logic need_div;
    logic per_div;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/stmg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Uses stmg_pkg for the dividend width.
`default_nettype none

module stmg_div #(
  parameter int DV = 22
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [stmg_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [DV-1:0]                   divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic [stmg_pkg::DIVIDEND_W-1:0]      quot
);

  localparam int CW = $clog2(stmg_pkg::DIVIDEND_W + 1);

  logic [DV-1:0]                   rem_r, rem_nxt;
  logic [stmg_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DV-1:0]                   div_r, div_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [DV:0]                     sh;
  logic [DV:0]                     diff;

  always_comb begin
    sh       = {rem_r, quo_r[stmg_pkg::DIVIDEND_W-1]};
    diff     = sh - {1'b0, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = CW'(stmg_pkg::DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, div_r}) begin
        rem_nxt = diff[DV-1:0];
        quo_nxt = {quo_r[stmg_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DV-1:0];
        quo_nxt = {quo_r[stmg_pkg::DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

@@ hdl/stmg_ctrl.sv @@
// Controller state machine of the motion generator.
// Uses stmg_pkg for states, commands and status.
`default_nettype none

module stmg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire stmg_pkg::sts_t sts,
  input  wire logic          div_done,
  output stmg_pkg::cmd_t     cmd
);

  stmg_pkg::state_t state_r, state_nxt;
  logic             ovld_r, ovld_nxt;
  logic             free;

  assign free = !ovld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stmg_pkg::ST_IDLE:  if (in_tvalid && free) state_nxt = stmg_pkg::ST_EXEC;
      stmg_pkg::ST_EXEC:  state_nxt = sts.step_go ? stmg_pkg::ST_SEL : stmg_pkg::ST_OUT;
      stmg_pkg::ST_SEL:   state_nxt = sts.need_div ? stmg_pkg::ST_RWAIT : stmg_pkg::ST_PMUL;
      stmg_pkg::ST_RWAIT: if (div_done) state_nxt = stmg_pkg::ST_PMUL;
      stmg_pkg::ST_PMUL:  state_nxt = stmg_pkg::ST_PSEL;
      stmg_pkg::ST_PSEL:  state_nxt = sts.per_div ? stmg_pkg::ST_PWAIT : stmg_pkg::ST_OUT;
      stmg_pkg::ST_PWAIT: if (div_done) state_nxt = stmg_pkg::ST_OUT;
      stmg_pkg::ST_OUT:   state_nxt = stmg_pkg::ST_IDLE;
      default:            state_nxt = stmg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    ovld_nxt  = ovld_r && !out_tready;
    case (state_r)
      stmg_pkg::ST_IDLE: begin
        in_tready = free;
        cmd.latch = in_tvalid && free;
      end
      stmg_pkg::ST_EXEC:  cmd.exec  = 1'b1;
      stmg_pkg::ST_SEL:   cmd.sel   = 1'b1;
      stmg_pkg::ST_RWAIT: cmd.rdone = div_done;
      stmg_pkg::ST_PMUL:  cmd.pmul  = 1'b1;
      stmg_pkg::ST_PSEL:  cmd.psel  = 1'b1;
      stmg_pkg::ST_PWAIT: cmd.pdone = div_done;
      stmg_pkg::ST_OUT: begin
        cmd.oload = 1'b1;
        ovld_nxt  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stmg_pkg::ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;

endmodule

`default_nettype wire

@@ hdl/stmg_dp.sv @@
// Datapath of the motion generator: settings, move state, ramp and period math.
// Uses stmg_pkg; drives the shared divider stmg_div.
`default_nettype none

module stmg_dp #(
  parameter int MICROSTEPS  = 3200,
  parameter int SPEED_LIMIT = 1200,
  parameter int DV          = 22,
  parameter int D_W         = 22
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire stmg_pkg::cmd_t                   cmd,
  output stmg_pkg::sts_t                        sts,
  input  wire logic [1:0]                       in_func,
  input  wire logic [20:0]                      in_dl,
  input  wire logic [20:0]                      in_dr,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_idx,
  input  wire logic [10:0]                      cfg_val,
  output logic                                  div_start,
  output logic [stmg_pkg::DIVIDEND_W-1:0]       div_a,
  output logic [DV-1:0]                         div_b,
  input  wire logic [stmg_pkg::DIVIDEND_W-1:0]  div_q,
  output logic [stmg_pkg::OUT_W-1:0]            out_word
);

  localparam int RPM_W = $clog2(SPEED_LIMIT + 1);

  logic [1:0]  func_r;
  logic [20:0] dl_r, dr_r;
  logic [10:0] min_r, max_r;
  logic [8:0]  af_r, df_r;
  logic        phase_r;
  logic [20:0] sc_r, tot_r, acc_r, dec_r, al_r, ar_r;
  logic signed [22:0] err_r;
  logic [1:0]  dir_r;
  logic [31:0] posl_r, posr_r;
  logic        active_r;
  logic [15:0] period_r;
  logic        stl_r, str_r;
  logic [RPM_W-1:0] rpm_r;
  logic [D_W-1:0]   d_r;
  logic [10:0] from_r;
  logic        neg_r;
  logic [stmg_pkg::OUT_W-1:0] out_r;

  logic [20:0] al, ar, tot, half;
  logic [29:0] pa, pd;
  logic [21:0] sum_ad;
  logic signed [23:0] e2;
  logic        cl, cr;
  logic [20:0] td, xr, span;
  logic        lt_acc, in_dec, dec_nz, need_div, more, per_div;
  logic [10:0] fr, to;
  logic signed [11:0] dsp;
  logic [10:0] mag;
  logic [31:0] prod;
  logic [11:0] raw_dir, raw_div;

  always_comb begin
    al     = dl_r[20] ? (~dl_r + 21'd1) : dl_r;
    ar     = dr_r[20] ? (~dr_r + 21'd1) : dr_r;
    tot    = (al > ar) ? al : ar;
    half   = {1'b0, tot[20:1]};
    pa     = tot * af_r;
    pd     = tot * df_r;
    sum_ad = {1'b0, pa[28:8]} + {1'b0, pd[28:8]};
    e2     = {err_r, 1'b0};
    cl     = e2 >= -$signed({3'b0, ar_r});
    cr     = e2 <= $signed({3'b0, al_r});

    td     = tot_r - dec_r;
    lt_acc = sc_r < acc_r;
    in_dec = sc_r >= td;
    dec_nz = dec_r != 21'd0;
    need_div = lt_acc || (in_dec && dec_nz);
    xr     = lt_acc ? sc_r : (sc_r - td);
    span   = lt_acc ? acc_r : dec_r;
    fr     = lt_acc ? min_r : max_r;
    to     = lt_acc ? max_r : min_r;
    dsp    = $signed({1'b0, to}) - $signed({1'b0, fr});
    mag    = dsp[11] ? 11'(-dsp) : dsp[10:0];
    prod   = xr * mag;
    raw_dir = (in_dec && !lt_acc) ? {1'b0, min_r} : {1'b0, max_r};
    raw_div = neg_r ? ({1'b0, from_r} - div_q[11:0]) : ({1'b0, from_r} + div_q[11:0]);

    more    = sc_r < tot_r;
    per_div = more && (rpm_r != '0);

    div_start = (cmd.sel && need_div) || (cmd.psel && per_div);
    div_a     = cmd.sel ? prod : stmg_pkg::PERIOD_NUM;
    div_b     = cmd.sel ? DV'(span) : DV'(d_r);

    sts.step_go  = (func_r == stmg_pkg::FUNC_TICK) && active_r && phase_r;
    sts.need_div = need_div;
    sts.per_div  = per_div;
  end

  function automatic logic [RPM_W-1:0] clamp(input logic [11:0] v);
    return (v > 12'(SPEED_LIMIT)) ? RPM_W'(SPEED_LIMIT) : RPM_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      dl_r   <= in_dl;
      dr_r   <= in_dr;
    end
    if (cmd.sel) begin
      from_r <= fr;
      neg_r  <= dsp[11];
      if (!need_div) rpm_r <= clamp(raw_dir);
    end
    if (cmd.rdone) rpm_r <= clamp(raw_div);
    if (cmd.pmul)  d_r <= D_W'(rpm_r * MICROSTEPS);
    if (cmd.oload) begin
      out_r <= {3'b0, posr_r, posl_r, active_r, period_r, dir_r[1], dir_r[0], str_r, stl_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= 11'd100;
      max_r    <= 11'd600;
      af_r     <= 9'd64;
      df_r     <= 9'd64;
      phase_r  <= 1'b0;
      sc_r     <= '0;
      tot_r    <= '0;
      acc_r    <= '0;
      dec_r    <= '0;
      err_r    <= '0;
      al_r     <= '0;
      ar_r     <= '0;
      dir_r    <= '0;
      posl_r   <= '0;
      posr_r   <= '0;
      active_r <= 1'b0;
      period_r <= stmg_pkg::PERIOD_MAX;
      stl_r    <= 1'b0;
      str_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          stmg_pkg::CFG_MIN_RPM:  min_r <= cfg_val;
          stmg_pkg::CFG_MAX_RPM:  max_r <= cfg_val;
          stmg_pkg::CFG_ACC_FRAC: af_r  <= cfg_val[8:0];
          stmg_pkg::CFG_DEC_FRAC: df_r  <= cfg_val[8:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        stl_r <= 1'b0;
        str_r <= 1'b0;
        case (func_r)
          stmg_pkg::FUNC_START: begin
            tot_r <= tot;
            sc_r  <= '0;
            if (tot == 21'd0) begin
              active_r <= 1'b0;
            end else begin
              dir_r <= {!dr_r[20] && (dr_r != 21'd0), !dl_r[20] && (dl_r != 21'd0)};
              if (sum_ad > {1'b0, tot}) begin
                acc_r <= half;
                dec_r <= half;
              end else begin
                acc_r <= pa[28:8];
                dec_r <= pd[28:8];
              end
              al_r     <= al;
              ar_r     <= ar;
              err_r    <= $signed({2'b0, al}) - $signed({2'b0, ar});
              active_r <= 1'b1;
            end
          end
          stmg_pkg::FUNC_TICK: begin
            if (active_r) begin
              phase_r <= !phase_r;
              if (phase_r) begin
                sc_r  <= sc_r + 21'd1;
                err_r <= err_r - (cl ? $signed({2'b0, ar_r}) : 23'sd0)
                               + (cr ? $signed({2'b0, al_r}) : 23'sd0);
                stl_r <= cl;
                str_r <= cr;
                if (cl) posl_r <= dir_r[0] ? posl_r + 32'd1 : posl_r - 32'd1;
                if (cr) posr_r <= dir_r[1] ? posr_r + 32'd1 : posr_r - 32'd1;
              end
            end
          end
          stmg_pkg::FUNC_ZERO: begin
            posl_r <= '0;
            posr_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.psel) begin
        if (!more) active_r <= 1'b0;
        else if (rpm_r == '0) period_r <= stmg_pkg::PERIOD_MAX;
      end
      if (cmd.pdone) begin
        period_r <= (div_q[31:16] != 16'd0) ? stmg_pkg::PERIOD_MAX : div_q[15:0];
      end
    end
  end

  assign out_word = out_r;

endmodule

`default_nettype wire

@@ hdl/two_axis_stepper_motion_generator.sv @@
// Path: start, zero and low-phase ticks go from an accepted word through EXEC to OUT;
// a step-phase tick also passes SEL, PMUL and PSEL, with up to two passes of the shared
// 32-bit divider (the ramp speed in RWAIT, the half period in PWAIT).
// Throughput: one word at a time; the next word is taken once the result register is free.
// Reset (rst_n, synchronous): settings return to 100/600 rpm and 64/256 shares,
// the move state clears and the half period reads 65535.
`default_nettype none

module two_axis_stepper_motion_generator #(
  parameter int MICROSTEPS  = 3200,
  parameter int SPEED_LIMIT = 1200
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // delta_left [20:0], delta_right [41:21], zero fill [47:42]
  input  wire logic [stmg_pkg::IN_W-1:0]   in_tdata,
  // func [1:0]
  input  wire logic [1:0]                  in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // step_left [0], step_right [1], dir_left [2], dir_right [3], half_period_us [19:4],
  // moving [20], position_left [52:21], position_right [84:53], zero fill [87:85]
  output logic [stmg_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [10:0]                 cfg_data
);

  localparam int D_W = $clog2(SPEED_LIMIT * MICROSTEPS + 1);
  localparam int DV  = (D_W > 21) ? D_W : 21;

  stmg_pkg::cmd_t cmd;
  stmg_pkg::sts_t sts;
  logic                            div_start, div_busy, div_done;
  logic [stmg_pkg::DIVIDEND_W-1:0] div_a, div_q;
  logic [DV-1:0]                   div_b;

  assign cfg_ready = 1'b1;

  stmg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .div_done   (div_done),
    .cmd        (cmd)
  );

  stmg_dp #(
    .MICROSTEPS  (MICROSTEPS),
    .SPEED_LIMIT (SPEED_LIMIT),
    .DV          (DV),
    .D_W         (D_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_tuser),
    .in_dl     (in_tdata[20:0]),
    .in_dr     (in_tdata[41:21]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .div_start (div_start),
    .div_a     (div_a),
    .div_b     (div_b),
    .div_q     (div_q),
    .out_word  (out_tdata)
  );

  stmg_div #(
    .DV (DV)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted while one is in flight");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("word accepted while result register stays occupied");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (div_busy && !div_done))
    else $error("divider did not start");

endmodule

`default_nettype wire
